@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the frame builder RTL.
// Each use expects signals named clk and arst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every edge outside reset.
`define ASSERT_AT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPL(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

@@ hw/rtl/scfb_pkg.sv @@
// Types and constants for the checksummed frame builder.
// No dependencies; imported by every scfb module.
`default_nettype none

package scfb_pkg;

	localparam int unsigned BURST_MAX = 4;
	localparam int unsigned CNT_W     = 3;
	localparam int unsigned LEFT_W    = 5;

	localparam logic [7:0] MAX_PAYLOAD   = 8'd28;
	localparam logic [7:0] HEADER_RESET  = 8'h88;

	localparam logic OP_START   = 1'b0;
	localparam logic OP_PAYLOAD = 1'b1;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_TOO_LONG = 2'd1,
		ST_IGNORED  = 2'd2
	} status_t;

	typedef struct packed {
		logic       opcode;
		logic [7:0] func_code;
		logic [7:0] payload_len;
		logic [7:0] payload_byte;
	} item_t;

	// Group of results caused by one item, oldest byte in entry 0.
	typedef struct packed {
		logic [BURST_MAX-1:0][7:0] bytes;
		logic [CNT_W-1:0]          cnt;
		logic                      last_end;
		status_t                   status;
	} burst_t;

endpackage

`default_nettype wire

@@ hw/rtl/scfb_frame_ctl.sv @@
// Frame state (bytes left, running sum, open flag) and result group encoding.
// Depends on scfb_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module scfb_frame_ctl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            adv,
	input  wire scfb_pkg::item_t item,
	input  wire logic [7:0]      header_byte,
	output scfb_pkg::burst_t     burst
);
	import scfb_pkg::*;

	logic [LEFT_W-1:0] bytes_left_q, bytes_left_d, left_dec;
	logic [7:0]        running_sum_q, running_sum_d, sum3, sum_pl;
	logic              frame_open_q, frame_open_d;
	logic              too_long;

	assign too_long = item.payload_len > MAX_PAYLOAD;
	assign sum3     = header_byte + item.func_code + item.payload_len;
	assign sum_pl   = running_sum_q + item.payload_byte;
	assign left_dec = bytes_left_q - LEFT_W'(1);

	always_comb begin
		burst         = '0;
		burst.status  = ST_OK;
		bytes_left_d  = bytes_left_q;
		running_sum_d = running_sum_q;
		frame_open_d  = frame_open_q;
		if (item.opcode == OP_START) begin
			frame_open_d = 1'b0;
			bytes_left_d = '0;
			if (too_long) begin
				burst.cnt    = CNT_W'(1);
				burst.status = ST_TOO_LONG;
			end else begin
				burst.bytes[0] = header_byte;
				burst.bytes[1] = item.func_code;
				burst.bytes[2] = item.payload_len;
				burst.bytes[3] = sum3;
				if (item.payload_len == 8'd0) begin
					burst.cnt      = CNT_W'(4);
					burst.last_end = 1'b1;
					running_sum_d  = '0;
				end else begin
					burst.cnt     = CNT_W'(3);
					running_sum_d = sum3;
					bytes_left_d  = item.payload_len[LEFT_W-1:0];
					frame_open_d  = 1'b1;
				end
			end
		end else if (!frame_open_q) begin
			burst.cnt    = CNT_W'(1);
			burst.status = ST_IGNORED;
		end else begin
			burst.bytes[0] = item.payload_byte;
			burst.bytes[1] = sum_pl;
			bytes_left_d   = left_dec;
			if (left_dec == '0) begin
				burst.cnt      = CNT_W'(2);
				burst.last_end = 1'b1;
				running_sum_d  = '0;
				frame_open_d   = 1'b0;
			end else begin
				burst.cnt     = CNT_W'(1);
				running_sum_d = sum_pl;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_left_q  <= '0;
			running_sum_q <= '0;
			frame_open_q  <= 1'b0;
		end else if (adv) begin
			bytes_left_q  <= bytes_left_d;
			running_sum_q <= running_sum_d;
			frame_open_q  <= frame_open_d;
		end
	end

	`ASSERT_IMPL(a_open_has_left, frame_open_q, bytes_left_q != '0,
		"open frame with no payload bytes left")
	`ASSERT_NEXT(a_start_closes, adv && item.opcode == OP_START && too_long,
		!frame_open_q, "rejected start left a frame open")

endmodule

`default_nettype wire

@@ hw/rtl/scfb_burst.sv @@
// Result serializer: holds one result group and shifts it out one byte per transfer.
// Depends on scfb_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module scfb_burst (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             load,
	input  wire scfb_pkg::burst_t burst,
	output logic                  free,
	output logic                  res_valid,
	input  wire logic             res_stall,
	output logic [7:0]            out_byte,
	output logic                  frame_end,
	output logic [1:0]            status
);
	import scfb_pkg::*;

	logic [BURST_MAX-1:0][7:0] bytes_q;
	logic [CNT_W-1:0]          cnt_q;
	logic                      end_q;
	status_t                   status_q;
	logic                      take;

	assign res_valid = cnt_q != '0;
	assign take      = res_valid && !res_stall;
	assign free      = (cnt_q == '0) || (cnt_q == CNT_W'(1) && !res_stall);
	assign out_byte  = bytes_q[0];
	assign frame_end = end_q && cnt_q == CNT_W'(1);
	assign status    = status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= burst.cnt;
		end else if (take) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bytes_q  <= burst.bytes;
			end_q    <= burst.last_end;
			status_q <= burst.status;
		end else if (take) begin
			bytes_q <= {8'd0, bytes_q[BURST_MAX-1:1]};
		end
	end

	`ASSERT_IMPL(a_load_when_free, load,
		(cnt_q == '0) || (cnt_q == CNT_W'(1) && !res_stall), "group loaded over pending results")
	`ASSERT_NEXT(a_group_continues, take && cnt_q > CNT_W'(1), res_valid,
		"result group cut short")

endmodule

`default_nettype wire

@@ hw/rtl/sum_checked_frame_builder.sv @@
// Top level of the checksummed frame builder: input register, header register,
// frame control and result serializer. Depends on scfb_pkg, scfb_frame_ctl, scfb_burst.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+-------------------------------------------
//   item     | item_valid / item_stall | opcode, func_code, payload_len, payload_byte
//   result   | res_valid / res_stall   | out_byte, frame_end, status
//   config   | cfg_valid / cfg_ready   | cfg_data (header byte)
//
// An item is registered, then encoded combinationally into a group of 1 to 4 results.
// Results leave one per cycle while res_stall is low; the number of results per item is
// payload bytes 1, closing byte 2, start 3 or 4, errors 1.
// The next item loads while the last result of a group transfers.
// Reset clears the frame state and sets the header byte to 0x88.
`default_nettype none

module sum_checked_frame_builder (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [7:0] cfg_data,
	input  wire logic       item_valid,
	output logic            item_stall,
	input  wire logic       opcode,
	input  wire logic [7:0] func_code,
	input  wire logic [7:0] payload_len,
	input  wire logic [7:0] payload_byte,
	output logic            res_valid,
	input  wire logic       res_stall,
	output logic [7:0]      out_byte,
	output logic            frame_end,
	output logic [1:0]      status
);
	import scfb_pkg::*;

	logic       cfg_wr;
	logic [7:0] header_byte_q;
	item_t      item_s1;
	logic       valid_s1;
	logic       adv, free, accept;
	burst_t     burst;

	assign cfg_ready  = 1'b1;
	assign adv        = valid_s1 && free;
	assign item_stall = valid_s1 && !adv;
	assign accept     = item_valid && !item_stall;
	assign cfg_wr     = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_byte_q <= HEADER_RESET;
			valid_s1      <= 1'b0;
		end else begin
			if (cfg_wr) begin
				header_byte_q <= cfg_data;
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= '{opcode: opcode, func_code: func_code,
				payload_len: payload_len, payload_byte: payload_byte};
		end
	end

	scfb_frame_ctl u_ctl (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.item        (item_s1),
		.header_byte (header_byte_q),
		.burst       (burst)
	);

	scfb_burst u_burst (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (adv),
		.burst     (burst),
		.free      (free),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.out_byte  (out_byte),
		.frame_end (frame_end),
		.status    (status)
	);

endmodule

`default_nettype wire

@@ dv/sum_checked_frame_builder_test.sv @@
// Self-checking testbench for sum_checked_frame_builder: a directed table, then random frames
// under three idle patterns and three header settings, checked against a local frame predictor.
// Depends on scfb_pkg and the sum_checked_frame_builder RTL.
`default_nettype none

module sum_checked_frame_builder_test;
	timeunit 1ns;
	timeprecision 1ps;

	import scfb_pkg::*;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		status_t    code;
	} res_t;

	typedef struct packed {
		logic       op;
		logic [7:0] func;
		logic [7:0] len;
		logic [7:0] data;
		logic [2:0] n;
		res_t [3:0] exp;
	} row_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [7:0] cfg_data = 8'h00;
	logic       item_valid = 1'b0;
	logic       item_stall;
	logic       opcode = OP_START;
	logic [7:0] func_code = 8'h00;
	logic [7:0] payload_len = 8'h00;
	logic [7:0] payload_byte = 8'h00;
	logic       res_valid;
	logic       res_stall = 1'b0;
	logic [7:0] out_byte;
	logic       frame_end;
	logic [1:0] status;

	// frame predictor state
	logic [7:0] hdr_byte = HEADER_RESET;
	logic [4:0] left_cnt = '0;
	logic [7:0] sum_acc = '0;
	logic       frame_open = 1'b0;

	res_t encoded[$];
	res_t typed_bytes[$];
	res_t pending_bytes[$];
	row_t directed_rows[$];

	int tx_idle = 14;
	int rx_idle = 62;
	int errors = 0;
	int n_items = 0;
	int n_closed = 0;
	int n_rejected = 0;
	int n_ignored = 0;
	int n_checked = 0;

	sum_checked_frame_builder DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.opcode(opcode),
		.func_code(func_code),
		.payload_len(payload_len),
		.payload_byte(payload_byte),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.out_byte(out_byte),
		.frame_end(frame_end),
		.status(status)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		res_stall <= ($urandom_range(99) < rx_idle);
	end

	initial begin
		#400_000;
		$display("sum_checked_frame_builder test failed");
		$finish;
	end

	function automatic res_t rb(logic [7:0] v, logic last, status_t c);
		res_t r;
		r.data = v;
		r.last = last;
		r.code = c;
		return r;
	endfunction

	task automatic encode_item(input logic op, input logic [7:0] f, l, d);
		encoded.delete();
		if (op == OP_START) begin
			frame_open = 1'b0;
			left_cnt = '0;
			if (l > MAX_PAYLOAD) begin
				encoded.push_back(rb(8'h00, 1'b0, ST_TOO_LONG));
				n_rejected++;
			end else begin
				encoded.push_back(rb(hdr_byte, 1'b0, ST_OK));
				encoded.push_back(rb(f, 1'b0, ST_OK));
				encoded.push_back(rb(l, 1'b0, ST_OK));
				sum_acc = hdr_byte + f + l;
				if (l == 8'd0) begin
					encoded.push_back(rb(sum_acc, 1'b1, ST_OK));
					sum_acc = '0;
					n_closed++;
				end else begin
					left_cnt = l[4:0];
					frame_open = 1'b1;
				end
			end
		end else if (!frame_open) begin
			encoded.push_back(rb(8'h00, 1'b0, ST_IGNORED));
			n_ignored++;
		end else begin
			encoded.push_back(rb(d, 1'b0, ST_OK));
			sum_acc = sum_acc + d;
			left_cnt = left_cnt - 5'd1;
			if (left_cnt == '0) begin
				encoded.push_back(rb(sum_acc, 1'b1, ST_OK));
				sum_acc = '0;
				frame_open = 1'b0;
				n_closed++;
			end
		end
	endtask

	// Returns just after the edge at which the item transferred.
	task automatic send_item(input logic op, input logic [7:0] f, l, d);
		while ($urandom_range(99) < tx_idle) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		encode_item(op, f, l, d);
		if (typed_bytes.size() != 0) begin
			foreach (typed_bytes[i]) pending_bytes.push_back(typed_bytes[i]);
			typed_bytes.delete();
		end else begin
			foreach (encoded[i]) pending_bytes.push_back(encoded[i]);
		end
		n_items++;
		item_valid <= 1'b1;
		opcode <= op;
		func_code <= f;
		payload_len <= l;
		payload_byte <= d;
		@(posedge clk);
		while (item_stall) @(posedge clk);
	endtask

	task automatic drain_results();
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending_bytes.size() != 0) @(posedge clk);
	endtask

	task automatic write_header(input logic [7:0] v);
		drain_results();
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		hdr_byte = v;
	endtask

	task automatic add_row(input logic op, input logic [7:0] f, l, d, input int n = 0,
			input res_t e0 = '0, input res_t e1 = '0, input res_t e2 = '0,
			input res_t e3 = '0);
		row_t r;
		r.op = op;
		r.func = f;
		r.len = l;
		r.data = d;
		r.n = n[2:0];
		r.exp[0] = e0;
		r.exp[1] = e1;
		r.exp[2] = e2;
		r.exp[3] = e3;
		directed_rows.push_back(r);
	endtask

	task automatic random_phase(input int n_target);
		int start_cnt;
		int cnt;
		logic [7:0] len;
		bit paused;
		start_cnt = n_items;
		paused = 0;
		while (n_items - start_cnt < n_target) begin
			if (!paused && n_items - start_cnt >= n_target / 2) begin
				drain_results();
				paused = 1;
			end
			if ($urandom_range(99) < 8) begin
				send_item(OP_PAYLOAD, 8'($urandom), 8'($urandom), 8'($urandom));
			end else begin
				case ($urandom_range(9))
					0: len = 8'($urandom_range(255, MAX_PAYLOAD + 1));
					1: len = MAX_PAYLOAD;
					2: len = 8'd0;
					default: len = 8'($urandom_range(8, 1));
				endcase
				send_item(OP_START, 8'($urandom), len, 8'($urandom));
				if (len <= MAX_PAYLOAD) begin
					cnt = len;
					// abandoned frame: next start arrives before the last payload byte
					if (len != 0 && $urandom_range(9) == 0) cnt = $urandom_range(len - 1, 0);
					repeat (cnt) begin
						send_item(OP_PAYLOAD, 8'($urandom), 8'($urandom), 8'($urandom));
					end
					if ($urandom_range(9) == 0) begin
						send_item(OP_PAYLOAD, 8'($urandom), 8'($urandom), 8'($urandom));
					end
				end
			end
		end
	endtask

	always @(posedge clk) begin
		res_t e;
		if (arst_n && res_valid && !res_stall) begin
			n_checked++;
			if (pending_bytes.size() == 0) begin
				$error("unexpected result: out_byte %02h frame_end %0d status %0d",
					out_byte, frame_end, status);
				errors++;
			end else begin
				e = pending_bytes.pop_front();
				if (out_byte !== e.data) begin
					$error("out_byte: expected %02h, actual %02h", e.data, out_byte);
					errors++;
				end
				if (frame_end !== e.last) begin
					$error("frame_end: expected %0d, actual %0d", e.last, frame_end);
					errors++;
				end
				if (status !== e.code) begin
					$error("status: expected %0d, actual %0d", e.code, status);
					errors++;
				end
			end
		end
	end

	initial begin
		logic [7:0] last_hdr;
		add_row(OP_PAYLOAD, 8'h00, 8'h00, 8'hFF, 1, rb(8'h00, 1'b0, ST_IGNORED));
		add_row(OP_START, 8'hFF, 8'd29, 8'h00, 1, rb(8'h00, 1'b0, ST_TOO_LONG));
		add_row(OP_START, 8'h00, 8'd255, 8'hFF, 1, rb(8'h00, 1'b0, ST_TOO_LONG));
		add_row(OP_START, 8'h00, 8'd0, 8'h00, 4, rb(8'h88, 1'b0, ST_OK),
			rb(8'h00, 1'b0, ST_OK), rb(8'h00, 1'b0, ST_OK), rb(8'h88, 1'b1, ST_OK));
		add_row(OP_START, 8'hFF, 8'd0, 8'hFF, 4, rb(8'h88, 1'b0, ST_OK),
			rb(8'hFF, 1'b0, ST_OK), rb(8'h00, 1'b0, ST_OK), rb(8'h87, 1'b1, ST_OK));
		add_row(OP_START, 8'h12, 8'd1, 8'h55);
		add_row(OP_PAYLOAD, 8'hAA, 8'hFF, 8'hFF);
		add_row(OP_PAYLOAD, 8'hFF, 8'h01, 8'h00, 1, rb(8'h00, 1'b0, ST_IGNORED));
		add_row(OP_START, 8'h5A, 8'd3, 8'h00);
		add_row(OP_PAYLOAD, 8'h00, 8'h00, 8'hA5);
		add_row(OP_START, 8'h33, 8'd2, 8'hFF);
		add_row(OP_PAYLOAD, 8'h00, 8'h00, 8'h00);
		add_row(OP_PAYLOAD, 8'hFF, 8'hFF, 8'hFF);
		add_row(OP_START, 8'hC3, MAX_PAYLOAD, 8'h00);
		add_row(OP_PAYLOAD, 8'h00, 8'h00, 8'h80);
		add_row(OP_START, 8'h00, MAX_PAYLOAD + 8'd1, 8'h00, 1,
			rb(8'h00, 1'b0, ST_TOO_LONG));
		add_row(OP_PAYLOAD, 8'h00, 8'h00, 8'h7F, 1, rb(8'h00, 1'b0, ST_IGNORED));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			for (int k = 0; k < directed_rows[i].n; k++) begin
				typed_bytes.push_back(directed_rows[i].exp[k]);
			end
			send_item(directed_rows[i].op, directed_rows[i].func, directed_rows[i].len,
				directed_rows[i].data);
		end

		write_header(8'hFF);
		random_phase(40);

		tx_idle = 62;
		rx_idle = 14;
		write_header(8'h00);
		random_phase(40);

		tx_idle = 0;
		rx_idle = 0;
		last_hdr = 8'($urandom_range(254, 1));
		write_header(last_hdr);
		random_phase(40);

		drain_results();
		repeat (8) @(posedge clk);

		$display("Covered %0d items and %0d result transfers: %0d frames closed,",
			n_items, n_checked, n_closed);
		$display("%0d starts rejected, %0d payloads ignored; header settings 88, ff, 00, %02h.",
			n_rejected, n_ignored, last_hdr);
		if (errors == 0) begin
			$display("sum_checked_frame_builder test passed");
		end else begin
			$display("sum_checked_frame_builder test failed");
		end
		$finish;
	end

endmodule

`default_nettype wire

@@ sum_checked_frame_builder.f @@
+incdir+hw/rtl
hw/rtl/scfb_pkg.sv
hw/rtl/scfb_frame_ctl.sv
hw/rtl/scfb_burst.sv
hw/rtl/sum_checked_frame_builder.sv
dv/sum_checked_frame_builder_test.sv
